// ===== sv/unsorted_key_table_unit_macros.svh =====
// Assertion macros used by the unsorted key table controller.
`ifndef UNSORTED_KEY_TABLE_UNIT_MACROS_SVH
`define UNSORTED_KEY_TABLE_UNIT_MACROS_SVH

// Property that must hold in the same cycle.
`define UKT_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Trigger in one cycle implies a consequence in the next cycle.
`define UKT_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ukt_pkg.sv =====
// Types and constants for the unsorted key table.
package ukt_pkg;

    localparam int CMD_W     = 3;
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 32;
    localparam int CAP_W     = 7;
    localparam int CNT_OUT_W = 7;
    localparam int CAP_RESET = 64;

    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RETRIEVE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MAKE_EMPTY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET_ITER = 3'd4;
    localparam logic [CMD_W-1:0] CMD_GET_NEXT   = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } in_item_t;

    typedef struct packed {
        logic                 status;
        logic                 found;
        logic [KEY_W-1:0]     key_out;
        logic [PAY_W-1:0]     payload_out;
        logic [CNT_OUT_W-1:0] count;
        logic                 full_res;
    } out_item_t;

    // Scan index source.
    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_CURSOR,
        IDX_LAST
    } idx_sel_t;

    // Controller to datapath.
    typedef struct packed {
        logic     load_in;
        idx_sel_t idx_sel;
        logic     wr_en;
        logic     wr_hole;
        logic     hole_load;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     cnt_clr;
        logic     cur_clr;
        logic     cur_inc;
        logic     set_ok;
        logic     set_found;
        logic     take_rd;
        logic     out_load;
    } ctl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             cnt_lt_cap;
        logic             cnt_zero;
        logic             cur_lt_cnt;
        logic             key_match;
        logic             scan_last;
    } ctl_sts_t;

endpackage

// ===== sv/unsorted_key_table_unit.sv =====
// Top level of the unsorted key table: controller plus datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  req     | in        | req_valid/req_stall  | in_item_t  (cmd, key, payload)
//  rsp     | out       | rsp_valid/rsp_stall  | out_item_t (status .. full_res)
//  cfg     | in        | cfg_we               | cfg_wdata  (capacity)
//
// Sequence: insert, make-empty, reset-iterator, undefined commands and anything
// failing without a scan go from decode straight to done; get-next first reads
// the entry at the cursor; retrieve/delete scan one entry a cycle from entry 0
// to a match or the last entry; delete then moves the last entry into the hole.
// Reset: count, cursor and capacity (64); entry memory is only read below count.
// Stalls: one result register; a new transfer is taken while it waits, and
// the next result is held in the datapath until the register frees up.
module unsorted_key_table_unit
    import ukt_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  in_item_t         req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output out_item_t        rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    ctl_cmd_t ctl;
    ctl_sts_t sts;

    // Sequencer: one command in flight, scan steps one entry a cycle.
    ukt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Entry memory (single write, single registered read) and bookkeeping.
    ukt_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .ctl       (ctl),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule

// ===== sv/ukt_dpath.sv =====
// Datapath: entry memory, counters, capacity register and result registers.
module ukt_dpath
    import ukt_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CAP_W-1:0]     cfg_wdata,
    input  in_item_t             req,
    input  ctl_cmd_t             ctl,
    output ctl_sts_t             sts,
    output out_item_t            rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ENT_W = KEY_W + PAY_W;

    logic [ENT_W-1:0] mem [DEPTH];

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] hole_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic [KEY_W-1:0] key_reg;
    logic [PAY_W-1:0] pay_reg;
    logic             res_st_reg;
    logic             res_fnd_reg;
    logic [KEY_W-1:0] res_key_reg;
    logic [PAY_W-1:0] res_pay_reg;
    logic [ENT_W-1:0] rdata_reg;
    out_item_t        rsp_reg;

    logic [CMP_W-1:0] cnt_ext, cap_ext, depth_ext;
    logic [CNT_W-1:0] last_idx;
    logic             is_full;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    assign cnt_ext   = CMP_W'(cnt_reg);
    assign cap_ext   = CMP_W'(cap_reg);
    assign depth_ext = CMP_W'(DEPTH);
    assign last_idx  = cnt_reg - 1'b1;
    // effective capacity saturates at DEPTH
    assign is_full   = (cnt_ext >= cap_ext) || (cnt_ext >= depth_ext);

    assign sts.cmd        = cmd_reg;
    assign sts.cnt_lt_cap = !is_full;
    assign sts.cnt_zero   = (cnt_reg == '0);
    assign sts.cur_lt_cnt = (cur_reg < cnt_reg);
    assign sts.key_match  = (rdata_reg[ENT_W-1:PAY_W] == key_reg);
    assign sts.scan_last  = (idx_reg == last_idx);

    always_comb
    begin
        unique case (ctl.idx_sel)
            IDX_ZERO:   idx_next = '0;
            IDX_INC:    idx_next = idx_reg + 1'b1;
            IDX_CURSOR: idx_next = cur_reg;
            IDX_LAST:   idx_next = last_idx;
            default:    idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        priority if (ctl.cnt_clr)
            cnt_next = '0;
        else if (ctl.cnt_inc)
            cnt_next = cnt_reg + 1'b1;
        else if (ctl.cnt_dec)
            cnt_next = cnt_reg - 1'b1;
        else
            cnt_next = cnt_reg;
    end

    always_comb
    begin
        priority if (ctl.cur_clr)
            cur_next = '0;
        else if (ctl.cur_inc)
            cur_next = cur_reg + 1'b1;
        else
            cur_next = cur_reg;
    end

    // Append goes to slot count; delete fills the hole with the last entry.
    assign wr_addr = ctl.wr_hole ? hole_reg : cnt_reg[IDX_W-1:0];
    assign wr_data = ctl.wr_hole ? rdata_reg : {key_reg, pay_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(CAP_RESET);
            cnt_reg <= '0;
            cur_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            cnt_reg <= cnt_next;
            cur_reg <= cur_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[wr_addr] <= wr_data;
        rdata_reg <= mem[idx_next[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg     <= req.cmd;
            key_reg     <= req.key;
            pay_reg     <= req.payload;
            res_st_reg  <= 1'b1;
            res_fnd_reg <= 1'b0;
            res_key_reg <= req.key;
            res_pay_reg <= req.payload;
        end
        else
        begin
            if (ctl.set_ok)
                res_st_reg <= 1'b0;
            if (ctl.set_found)
                res_fnd_reg <= 1'b1;
            if (ctl.take_rd)
            begin
                res_key_reg <= rdata_reg[ENT_W-1:PAY_W];
                res_pay_reg <= rdata_reg[PAY_W-1:0];
            end
        end
        if (ctl.hole_load)
            hole_reg <= idx_reg[IDX_W-1:0];
        if (ctl.out_load)
        begin
            rsp_reg.status      <= res_st_reg;
            rsp_reg.found       <= res_fnd_reg;
            rsp_reg.key_out     <= res_key_reg;
            rsp_reg.payload_out <= res_pay_reg;
            rsp_reg.count       <= cnt_ext[CNT_OUT_W-1:0];
            rsp_reg.full_res    <= is_full;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== sv/ukt_ctrl.sv =====
// Controller state machine for the unsorted key table.
`include "unsorted_key_table_unit_macros.svh"

module ukt_ctrl
    import ukt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    input  ctl_sts_t sts,
    output ctl_cmd_t ctl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_GNEXT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                unique case (sts.cmd)
                    CMD_INSERT:
                    begin
                        if (sts.cnt_lt_cap)
                        begin
                            ctl.wr_en   = 1'b1;
                            ctl.cnt_inc = 1'b1;
                            ctl.set_ok  = 1'b1;
                        end
                    end
                    CMD_DELETE, CMD_RETRIEVE:
                    begin
                        if (!sts.cnt_zero)
                        begin
                            ctl.idx_sel = IDX_ZERO;
                            state_next  = S_SCAN;
                        end
                    end
                    CMD_MAKE_EMPTY:
                    begin
                        ctl.cnt_clr = 1'b1;
                        ctl.set_ok  = 1'b1;
                    end
                    CMD_RESET_ITER:
                    begin
                        ctl.cur_clr = 1'b1;
                        ctl.set_ok  = 1'b1;
                    end
                    CMD_GET_NEXT:
                    begin
                        if (sts.cur_lt_cnt)
                        begin
                            ctl.idx_sel = IDX_CURSOR;
                            state_next  = S_GNEXT;
                        end
                    end
                    default:
                    begin
                        // undefined command: echo input, report failure
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.key_match)
                begin
                    if (sts.cmd == CMD_RETRIEVE)
                    begin
                        ctl.take_rd   = 1'b1;
                        ctl.set_found = 1'b1;
                        ctl.set_ok    = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        ctl.hole_load = 1'b1;
                        ctl.idx_sel   = IDX_LAST;
                        state_next    = S_MOVE;
                    end
                end
                else if (sts.scan_last)
                    state_next = S_DONE;
                else
                    ctl.idx_sel = IDX_INC;
            end
            S_MOVE:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_hole = 1'b1;
                ctl.cnt_dec = 1'b1;
                ctl.set_ok  = 1'b1;
                state_next  = S_DONE;
            end
            S_GNEXT:
            begin
                ctl.take_rd = 1'b1;
                ctl.cur_inc = 1'b1;
                ctl.set_ok  = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = ctl.out_load | (out_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `UKT_ASSERT(a_load_slot_free, !ctl.out_load || !out_valid_reg || !rsp_stall, "result lost")
    `UKT_ASSERT_NEXT(a_accept_decode, req_valid && !req_stall, state_reg == S_DECODE, "no decode")
    `UKT_ASSERT(a_scan_nonempty, state_reg != S_SCAN || !sts.cnt_zero, "scan of empty table")
    `UKT_ASSERT(a_insert_room, !ctl.cnt_inc || sts.cnt_lt_cap, "insert past capacity")
    `UKT_ASSERT_NEXT(a_load_valid, ctl.out_load, rsp_valid, "loaded result not presented")

endmodule
